// ===== hdl/rgbsat_pkg.sv =====
package rgbsat_pkg;

  // ratio r = lo/hi as Q0.32, log fraction in Q.16
  localparam int RATIO_BITS = 32;
  localparam int LOG_FRAC   = 16;
  localparam int GAMMA_INT  = 4;
  localparam int Y_BITS     = 22;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // t_k ~ 2^32 * 2^(-2^-k), k = 1..LOG_FRAC, entry k-1 at [32*(k-1) +: 32]
  function automatic logic [LOG_FRAC*32-1:0] root_table();
    logic [LOG_FRAC*32-1:0] tab;
    logic [63:0] t;
    tab = '0;
    t = 64'd1 << 31;
    for (int k = 0; k < LOG_FRAC; k++) begin
      t = isqrt64(t << 32);
      tab[32*k +: 32] = t[31:0];
    end
    return tab;
  endfunction

  localparam logic [LOG_FRAC*32-1:0] ROOT_TAB = root_table();

endpackage

// ===== hdl/rgb_gamma_saturation_adjust_core.sv =====
// RGB saturation adjust: the low channel of a pixel becomes hi*(lo/hi)^gamma and
// the strictly middle channel is remapped linearly between the new low and hi.
// Pixels with hi == lo or lo == 0 pass unchanged.
//
// Channels: in_* and out_* are valid/ready streams, one pixel per beat.
// cfg_* writes the gamma register (unsigned, GAMMA_FRAC_BITS fraction bits);
// cfg_ready is always high. Write gamma only while the pipe is empty.
//
// Throughput: one pixel per clock while the receiver takes beats. The pixel pipe
// runs through the bit-serial ratio divider (32 stages), the log squaring chain
// (16 stages), the exp root-multiply chain (16 stages) and the middle-channel
// divider (CHANNEL_BITS stages).
//
// A stalled receiver freezes the whole pipe: in_ready drops when the output
// register holds a beat that is not taken; bubbles in flight are not squeezed out.
// Reset (rst_n low, synchronous) empties the pipe and sets gamma to 1.0.
module rgb_gamma_saturation_adjust_core
  import rgbsat_pkg::*;
#(
  parameter int CHANNEL_BITS    = 16,
  parameter int GAMMA_FRAC_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [GAMMA_FRAC_BITS+GAMMA_INT-1:0]   cfg_gamma,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [CHANNEL_BITS-1:0]                in_red_in,
  input  logic [CHANNEL_BITS-1:0]                in_green_in,
  input  logic [CHANNEL_BITS-1:0]                in_blue_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [CHANNEL_BITS-1:0]                out_red_out,
  output logic [CHANNEL_BITS-1:0]                out_green_out,
  output logic [CHANNEL_BITS-1:0]                out_blue_out
);

  localparam int CB = CHANNEL_BITS;
  localparam int GF = GAMMA_FRAC_BITS;
  localparam int GB = GF + GAMMA_INT;
  localparam int QB = RATIO_BITS;
  localparam int LF = LOG_FRAC;
  localparam int PW = Y_BITS + GB - GF;
  localparam int NW = PW - LF;
  localparam int MW = QB + 1;
  // stage positions along the pixel pipe
  localparam int NS = QB + 1;
  localparam int PS = NS + LF + 1;
  localparam int SH = PS + LF + 1;
  localparam int NL = SH + 1;
  localparam int PR = NL + 1;
  localparam int OS = PR + CB + 1;

  localparam logic [Y_BITS-1:0] Y_TOP = Y_BITS'(QB) << LF;
  localparam logic [MW-1:0]     M_ONE = MW'(1) << QB;

  typedef struct packed {
    logic [CB-1:0] c0;
    logic [CB-1:0] c1;
    logic [CB-1:0] c2;
    logic [CB-1:0] hi;
    logic [CB-1:0] lo;
    logic [CB-1:0] md;
    logic          has_md;
    logic          act;
  } pix_t;

  logic          adv;
  logic [GB-1:0] gamma_r;

  pix_t pix_r   [0:OS-1];
  pix_t srt_nxt;
  logic valid_r [0:OS-1];

  logic [CB-1:0] d1_rem_r [0:QB];
  logic [CB-1:0] d1_rem_nxt [0:QB];
  logic [QB-1:0] d1_q_r   [0:QB];
  logic [QB-1:0] d1_q_nxt [0:QB];

  logic [QB-1:0] sq_x_r   [0:LF];
  logic [QB-1:0] sq_x_nxt [0:LF];
  logic [LF-1:0] sq_f_r   [0:LF];
  logic [LF-1:0] sq_f_nxt [0:LF];
  logic [4:0]    sq_e_r   [0:LF];
  logic [4:0]    sq_e_nxt [0:LF];

  logic [MW-1:0] ex_m_r   [0:LF];
  logic [MW-1:0] ex_m_nxt [0:LF];
  logic [LF-1:0] ex_f_r   [0:LF];
  logic [LF-1:0] ex_f_nxt [0:LF];
  logic [NW-1:0] ex_n_r   [0:LF];
  logic [NW-1:0] ex_n_nxt [0:LF];

  logic [MW-1:0] sh_m_r, sh_m_nxt;
  logic [CB-1:0] nl_r, nl_nxt;

  logic [CB-1:0] dv_rem_r   [0:CB];
  logic [CB-1:0] dv_rem_nxt [0:CB];
  logic [CB-1:0] dv_low_r   [0:CB];
  logic [CB-1:0] dv_low_nxt [0:CB];
  logic [CB-1:0] dv_div_r   [0:CB];
  logic [CB-1:0] dv_div_nxt [0:CB];
  logic [CB-1:0] dv_q_r     [0:CB];
  logic [CB-1:0] dv_q_nxt   [0:CB];
  logic [CB-1:0] dv_nl_r    [0:CB];
  logic [CB-1:0] dv_nl_nxt  [0:CB];

  logic          out_valid_r;
  logic [CB-1:0] out_red_r, out_green_r, out_blue_r;
  logic [CB-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

  // sort
  always_comb begin
    logic [CB-1:0] c [0:2];
    logic [CB-1:0] hi, lo, md;
    logic          has_md;
    c[0] = in_red_in;
    c[1] = in_green_in;
    c[2] = in_blue_in;
    hi = c[0];
    lo = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] > hi) hi = c[i];
      if (c[i] < lo) lo = c[i];
    end
    md = '0;
    has_md = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (c[i] < hi && c[i] > lo) begin
        md = c[i];
        has_md = 1'b1;
      end
    end
    srt_nxt.c0     = c[0];
    srt_nxt.c1     = c[1];
    srt_nxt.c2     = c[2];
    srt_nxt.hi     = hi;
    srt_nxt.lo     = lo;
    srt_nxt.md     = md;
    srt_nxt.has_md = has_md;
    srt_nxt.act    = (hi > lo) && (lo != '0);
  end

  // ratio lo*2^32/hi, one quotient bit per stage
  always_comb begin
    logic [CB:0] t;
    d1_rem_nxt[0] = srt_nxt.lo;
    d1_q_nxt[0]   = '0;
    for (int k = 1; k <= QB; k++) begin
      t = {d1_rem_r[k-1], 1'b0};
      if (t >= {1'b0, pix_r[k-1].hi}) begin
        d1_rem_nxt[k] = CB'(t - {1'b0, pix_r[k-1].hi});
        d1_q_nxt[k]   = {d1_q_r[k-1][QB-2:0], 1'b1};
      end else begin
        d1_rem_nxt[k] = t[CB-1:0];
        d1_q_nxt[k]   = {d1_q_r[k-1][QB-2:0], 1'b0};
      end
    end
  end

  // normalize, then one log2 fraction bit per squaring stage
  always_comb begin
    logic [QB-1:0]   r;
    logic [4:0]      e;
    logic [2*QB-1:0] sq;
    logic [QB:0]     xs;
    r = d1_q_r[QB];
    e = '0;
    for (int i = 0; i < QB; i++) begin
      if (r[i]) e = 5'(i);
    end
    sq_x_nxt[0] = r << (5'(QB - 1) - e);
    sq_f_nxt[0] = '0;
    sq_e_nxt[0] = e;
    for (int j = 1; j <= LF; j++) begin
      sq = {{QB{1'b0}}, sq_x_r[j-1]} * {{QB{1'b0}}, sq_x_r[j-1]};
      xs = sq[QB-1 +: QB+1];
      sq_e_nxt[j] = sq_e_r[j-1];
      if (xs[QB]) begin
        sq_x_nxt[j] = xs[QB:1];
        sq_f_nxt[j] = {sq_f_r[j-1][LF-2:0], 1'b1};
      end else begin
        sq_x_nxt[j] = xs[QB-1:0];
        sq_f_nxt[j] = {sq_f_r[j-1][LF-2:0], 1'b0};
      end
    end
  end

  // p = y*gamma, then exp2 by root multiplies
  always_comb begin
    logic [Y_BITS-1:0]    y;
    logic [Y_BITS+GB-1:0] yg;
    logic [PW-1:0]        p;
    logic [MW+QB-1:0]     mp;
    y  = Y_TOP - Y_BITS'({sq_e_r[LF], sq_f_r[LF]});
    yg = {{GB{1'b0}}, y} * {{Y_BITS{1'b0}}, gamma_r};
    p  = yg[GF +: PW];
    ex_m_nxt[0] = M_ONE;
    ex_f_nxt[0] = p[LF-1:0];
    ex_n_nxt[0] = p[PW-1:LF];
    for (int k = 1; k <= LF; k++) begin
      mp = {{QB{1'b0}}, ex_m_r[k-1]} * {{MW{1'b0}}, ROOT_TAB[32*(k-1) +: 32]};
      ex_f_nxt[k] = ex_f_r[k-1];
      ex_n_nxt[k] = ex_n_r[k-1];
      if (ex_f_r[k-1][LF-k]) ex_m_nxt[k] = mp[QB +: MW];
      else                   ex_m_nxt[k] = ex_m_r[k-1];
    end
  end

  // scale and new low
  always_comb begin
    logic [CB+MW-1:0] hm;
    sh_m_nxt = ex_m_r[LF] >> ex_n_r[LF];
    hm = {{MW{1'b0}}, pix_r[SH].hi} * {{CB{1'b0}}, sh_m_r};
    nl_nxt = pix_r[SH].act ? hm[QB +: CB] : pix_r[SH].lo;
  end

  // (md-lo)*(hi-newlo)/(hi-lo), one quotient bit per stage
  always_comb begin
    logic [2*CB-1:0] dd;
    logic [CB:0]     t;
    dd = {{CB{1'b0}}, CB'(pix_r[NL].md - pix_r[NL].lo)} *
         {{CB{1'b0}}, CB'(pix_r[NL].hi - nl_r)};
    dv_rem_nxt[0] = dd[2*CB-1:CB];
    dv_low_nxt[0] = dd[CB-1:0];
    dv_div_nxt[0] = pix_r[NL].hi - pix_r[NL].lo;
    dv_q_nxt[0]   = '0;
    dv_nl_nxt[0]  = nl_r;
    for (int k = 1; k <= CB; k++) begin
      t = {dv_rem_r[k-1], dv_low_r[k-1][CB-1]};
      dv_low_nxt[k] = dv_low_r[k-1] << 1;
      dv_div_nxt[k] = dv_div_r[k-1];
      dv_nl_nxt[k]  = dv_nl_r[k-1];
      if (t >= {1'b0, dv_div_r[k-1]}) begin
        dv_rem_nxt[k] = CB'(t - {1'b0, dv_div_r[k-1]});
        dv_q_nxt[k]   = CB'({dv_q_r[k-1], 1'b1});
      end else begin
        dv_rem_nxt[k] = t[CB-1:0];
        dv_q_nxt[k]   = CB'({dv_q_r[k-1], 1'b0});
      end
    end
  end

  // channel replace, matched against original lo then md
  always_comb begin
    pix_t          px;
    logic [CB-1:0] newlo, newmd;
    px    = pix_r[OS-1];
    newlo = dv_nl_r[CB];
    newmd = px.act ? CB'(newlo + dv_q_r[CB]) : px.md;
    out_red_nxt   = px.c0;
    out_green_nxt = px.c1;
    out_blue_nxt  = px.c2;
    if (px.c0 == px.lo)                    out_red_nxt = newlo;
    else if (px.has_md && px.c0 == px.md)  out_red_nxt = newmd;
    if (px.c1 == px.lo)                    out_green_nxt = newlo;
    else if (px.has_md && px.c1 == px.md)  out_green_nxt = newmd;
    if (px.c2 == px.lo)                    out_blue_nxt = newlo;
    else if (px.has_md && px.c2 == px.md)  out_blue_nxt = newmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GB'(1) << GF;
    end else if (cfg_valid) begin
      gamma_r <= cfg_gamma;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < OS; i++) valid_r[i] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < OS; i++) valid_r[i] <= valid_r[i-1];
      out_valid_r <= valid_r[OS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r[0] <= srt_nxt;
      for (int i = 1; i < OS; i++) pix_r[i] <= pix_r[i-1];
      for (int k = 0; k <= QB; k++) begin
        d1_rem_r[k] <= d1_rem_nxt[k];
        d1_q_r[k]   <= d1_q_nxt[k];
      end
      for (int j = 0; j <= LF; j++) begin
        sq_x_r[j] <= sq_x_nxt[j];
        sq_f_r[j] <= sq_f_nxt[j];
        sq_e_r[j] <= sq_e_nxt[j];
        ex_m_r[j] <= ex_m_nxt[j];
        ex_f_r[j] <= ex_f_nxt[j];
        ex_n_r[j] <= ex_n_nxt[j];
      end
      sh_m_r <= sh_m_nxt;
      nl_r   <= nl_nxt;
      for (int k = 0; k <= CB; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_low_r[k] <= dv_low_nxt[k];
        dv_div_r[k] <= dv_div_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
        dv_nl_r[k]  <= dv_nl_nxt[k];
      end
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
    end
  end

endmodule
